/* hdl/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hdl/rtcenc_pkg.sv */
// Types, constants and helper functions for the RTC time check and BCD encoder.
package rtcenc_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned EpochW   = 12;

  localparam logic [EpochW-1:0] EpochReset   = 12'd2000;
  localparam logic [EpochW-1:0] YearBase     = 12'd1900;
  localparam logic [9:0]        MinYearOfs   = 10'd70;
  localparam logic [EpochW-1:0] EpochSpan    = 12'd169;
  localparam logic [EpochW-1:0] Century      = 12'd100;
  localparam logic [3:0]        MonthMax     = 4'd11;
  localparam logic [3:0]        MonthFeb     = 4'd1;
  localparam logic [4:0]        HourLimit    = 5'd24;
  localparam logic [5:0]        SixtyLimit   = 6'd60;
  localparam logic [7:0]        Hour24Flag   = 8'h80;

  localparam logic RegEpochYear = 1'b0;

  typedef struct packed {
    logic [9:0] year_since_1900;
    logic [3:0] month_index;
    logic [5:0] day_of_month;
    logic [4:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;
  } item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] hour_code;
    logic [7:0] minute_code;
    logic [7:0] second_code;
    logic [7:0] year_code;
    logic [7:0] month_code;
    logic [7:0] date_code;
  } res_t;

  function automatic logic [4:0] month_days(input logic [3:0] mon);
    logic [4:0] d;
    case (mon)
      4'd1:                      d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // Gregorian leap test on the offset from 1900: a multiple of 4 but not of 100, or one of 100, 500 and 900.
  function automatic logic leap_year(input logic [9:0] y);
    logic cent;
    logic quad;
    cent = 1'b0;
    for (int k = 0; k <= 10; k++) begin
      if (y == 10'(k * 100)) cent = 1'b1;
    end
    quad = (y == 10'd100) || (y == 10'd500) || (y == 10'd900);
    return ((y[1:0] == 2'b00) && !cent) || quad;
  endfunction

  // Packed BCD of a value below 100; tens by reciprocal multiply.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(7'({3'b000, tens}) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

/* hdl/rtcenc_enc.sv */
// Calendar time check and packed BCD encoding of one transaction.
module rtcenc_enc import rtcenc_pkg::*; (
  input  item_t             item_i,
  input  logic [EpochW-1:0] epoch_i,
  output res_t              res_o
);

  logic [EpochW-1:0] year_full;
  logic [EpochW-1:0] diff;
  logic [6:0]        yrs;
  logic [5:0]        limit;
  logic              leap;
  logic              date_ok;
  logic              clock_ok;
  logic              year_ok;
  logic              ok;

  assign year_full = 12'(item_i.year_since_1900) + YearBase;
  assign leap      = leap_year(item_i.year_since_1900);
  assign limit     = 6'(month_days(item_i.month_index))
                   + 6'((item_i.month_index == MonthFeb) && leap);
  assign date_ok   = (item_i.month_index <= MonthMax) && (item_i.day_of_month != 6'd0)
                   && (item_i.day_of_month <= limit);
  assign clock_ok  = (item_i.hour_value < HourLimit) && (item_i.minute_value < SixtyLimit)
                   && (item_i.second_value < SixtyLimit);
  assign diff      = year_full - epoch_i;
  assign year_ok   = (item_i.year_since_1900 >= MinYearOfs) && (year_full >= epoch_i)
                   && (diff <= EpochSpan);
  assign yrs       = (diff >= Century) ? 7'(diff - Century) : 7'(diff);
  assign ok        = date_ok && clock_ok && year_ok;

  always_comb begin
    res_o = '0;
    res_o.status = 1'b1;
    if (ok) begin
      res_o.status      = 1'b0;
      res_o.hour_code   = Hour24Flag | to_bcd(7'(item_i.hour_value));
      res_o.minute_code = to_bcd(7'(item_i.minute_value));
      res_o.second_code = to_bcd(7'(item_i.second_value));
      res_o.year_code   = to_bcd(yrs);
      res_o.month_code  = to_bcd(7'(item_i.month_index) + 7'd1);
      res_o.date_code   = to_bcd(7'(item_i.day_of_month));
    end
  end

endmodule

/* hdl/rtc_time_validate_encode.sv */
// Top level of the RTC time check and BCD encoder with its register port.
//
// Input channel: in_valid_i/in_ready_o carry one broken-down calendar time
// per transaction. Output channel: out_valid_o/out_ready_i carry one result
// per input: status_o (0 valid, 1 rejected) and six packed BCD bytes, all
// zero on a rejected time.
// Pipeline: an accepted transaction is held in the input register and its
// result in the result register, a two-stage pipeline with the check logic
// between them; one transaction per cycle while out_ready_i is high.
// Stall: when out_ready_i is low the result holds; the input register still
// takes a transaction while it is empty, and in_ready_o drops only when both
// stages are full.
// Register port: epoch_year at byte address 0, written through psel/penable/
// pwrite, read back on prdata; pready is tied high. Write it only while idle.
// Reset: both stages empty, epoch_year back to 2000.
module rtc_time_validate_encode import rtcenc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [9:0]          year_since_1900_i,
  input  logic [3:0]          month_index_i,
  input  logic [5:0]          day_of_month_i,
  input  logic [4:0]          hour_value_i,
  input  logic [5:0]          minute_value_i,
  input  logic [5:0]          second_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                status_o,
  output logic [7:0]          hour_code_o,
  output logic [7:0]          minute_code_o,
  output logic [7:0]          second_code_o,
  output logic [7:0]          year_code_o,
  output logic [7:0]          month_code_o,
  output logic [7:0]          date_code_o
);

  logic [EpochW-1:0] epoch_q;
  logic              s1_valid_q;
  item_t             s1_item_q;
  logic              out_valid_q;
  res_t              out_res_q;
  res_t              res;
  logic              out_free;
  logic              s1_adv;
  logic              in_acc;
  logic              cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == RegEpochYear);
  assign prdata   = (paddr[2] == RegEpochYear) ? CfgDataW'(epoch_q) : '0;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  rtcenc_enc u_enc (
    .item_i  (s1_item_q),
    .epoch_i (epoch_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q     <= EpochReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        epoch_q <= pwdata[EpochW-1:0];
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= '{year_since_1900: year_since_1900_i, month_index: month_index_i,
                     day_of_month: day_of_month_i, hour_value: hour_value_i,
                     minute_value: minute_value_i, second_value: second_value_i};
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_res_q.status;
  assign hour_code_o   = out_res_q.hour_code;
  assign minute_code_o = out_res_q.minute_code;
  assign second_code_o = out_res_q.second_code;
  assign year_code_o   = out_res_q.year_code;
  assign month_code_o  = out_res_q.month_code;
  assign date_code_o   = out_res_q.date_code;

endmodule

/* hdl/rtcenc_chk.sv */
// Port-level checker for the RTC time encoder, bound to the top level.
`include "assert_macros.svh"

module rtcenc_chk import rtcenc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic                status_o,
  input logic [7:0]          hour_code_o,
  input logic [7:0]          minute_code_o,
  input logic [7:0]          second_code_o,
  input logic [7:0]          year_code_o,
  input logic [7:0]          month_code_o,
  input logic [7:0]          date_code_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(status_o) && $stable(hour_code_o) && $stable(year_code_o)
    && $stable(date_code_o))

  `ASSERT_IMPLY(a_reject_zero, clk_i, rst_ni, out_valid_o && status_o,
    hour_code_o == 8'h00 && minute_code_o == 8'h00 && second_code_o == 8'h00
    && year_code_o == 8'h00 && month_code_o == 8'h00 && date_code_o == 8'h00)

  `ASSERT_IMPLY(a_accept_fields, clk_i, rst_ni, out_valid_o && !status_o,
    hour_code_o[7] && hour_code_o[6] == 1'b0 && hour_code_o[5:4] <= 2'd2
    && minute_code_o[7:4] <= 4'd5 && second_code_o[7:4] <= 4'd5
    && year_code_o[7:4] <= 4'd9 && year_code_o[3:0] <= 4'd9
    && month_code_o != 8'h00 && month_code_o <= 8'h12
    && date_code_o != 8'h00 && date_code_o <= 8'h31)

  `ASSERT_IMPLY(a_ready_when_free, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o)

endmodule

bind rtc_time_validate_encode rtcenc_chk u_rtcenc_chk (.*);
